// ===== design/two_path_grid_max_sum_top_macros.svh =====
// ----------------------------------------------------------------------------
// two path grid max sum assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TWO_PATH_GRID_MAX_SUM_TOP_MACROS_SVH
`define TWO_PATH_GRID_MAX_SUM_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TPGM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TPGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tpgm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpgm_pkg
// widths, constants and shared types of the two path grid max sum block
// ----------------------------------------------------------------------------
package tpgm_pkg;

   localparam int COORD_W = 5;
   localparam int SIDE_W  = 5;
   localparam int VALUE_W = 16;
   localparam int TOTAL_W = 22;
   localparam int CELL_W  = VALUE_W + 1;

   localparam logic [SIDE_W-1:0]  SIDE_RESET = 5'd16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 22'h3FFFFF;

   // per-cycle control from the walk sequencer to the cell accumulator,
   // aligned with the read data it refers to
   typedef struct packed {
      logic take_t1;    // grid data is the first path's cell
      logic take_t2;    // grid data is the second path's cell
      logic shared;     // both paths sit on the same cell
      logic take_p;     // dp data is a predecessor
      logic first_p;    // first predecessor of the cell
      logic p_valid;    // predecessor lies inside the previous layer
      logic commit;     // write the cell result now
      logic last_cell;  // cell is the bottom-right corner
   } step_ctl_type;

endpackage

// ===== design/tpgm_if.sv =====
// ----------------------------------------------------------------------------
// tpgm channel interfaces
// valid/ready channels for cell writes, results and the side register
// ----------------------------------------------------------------------------
interface tpgm_req_if import tpgm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, row, col, value, last, input ready);
   modport sink (input valid, row, col, value, last, output ready);
endinterface

interface tpgm_rsp_if import tpgm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] total;

   modport source (output valid, total, input ready);
   modport sink (input valid, total, output ready);
endinterface

interface tpgm_csr_if import tpgm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== design/tpgm_ram.sv =====
// ----------------------------------------------------------------------------
// tpgm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tpgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tpgm_acc.sv =====
// ----------------------------------------------------------------------------
// tpgm_acc
// collects cell values and the best predecessor of one dp entry
// ----------------------------------------------------------------------------
module tpgm_acc import tpgm_pkg::*; (
   input  logic               clock,
   input  step_ctl_type       ctl,
   input  logic [VALUE_W-1:0] grid_rd_data,
   input  logic [TOTAL_W-1:0] dp_rd_data,
   output logic [TOTAL_W-1:0] sum
);

   logic [CELL_W-1:0]  t_ff;
   logic [TOTAL_W-1:0] best_ff;
   logic [TOTAL_W-1:0] pred;
   logic [TOTAL_W:0]   sum_wide;

   // out-of-layer predecessors count as zero
   assign pred = ctl.p_valid ? dp_rd_data : '0;

   always_ff @(posedge clock) begin
      if (ctl.take_t1) begin
         t_ff <= CELL_W'(grid_rd_data);
      end else if (ctl.take_t2 && !ctl.shared) begin
         t_ff <= t_ff + CELL_W'(grid_rd_data);
      end
      if (ctl.take_p) begin
         if (ctl.first_p || (pred > best_ff)) begin
            best_ff <= pred;
         end
      end
   end

   // saturating add, overflow shows in the top bit
   assign sum_wide = {1'b0, best_ff} + (TOTAL_W + 1)'(t_ff);
   assign sum      = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

endmodule

// ===== design/tpgm_walk.sv =====
// ----------------------------------------------------------------------------
// tpgm_walk
// anti-diagonal walk over row pairs, one dp entry after another
// ----------------------------------------------------------------------------
`include "two_path_grid_max_sum_top_macros.svh"

module tpgm_walk import tpgm_pkg::*; #(
   parameter int MAX_SIDE = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(MAX_SIDE + 1)-1:0]      side,
   output logic [2*$clog2(MAX_SIDE)-1:0]        grid_rd_addr,
   output logic [2*$clog2(MAX_SIDE):0]          dp_rd_addr,
   output logic [2*$clog2(MAX_SIDE):0]          dp_wr_addr,
   output step_ctl_type                         ctl,
   output logic                                 busy
);

   localparam int RW = $clog2(MAX_SIDE);
   localparam int IW = $clog2(MAX_SIDE + 1);
   localparam int KW = $clog2(2 * MAX_SIDE + 1);

   // phases of one entry; reads issued in the first four
   localparam logic [2:0] PH_GRID_A = 3'd0;
   localparam logic [2:0] PH_GRID_B = 3'd1;
   localparam logic [2:0] PH_PRED_C = 3'd2;
   localparam logic [2:0] PH_PRED_D = 3'd3;
   localparam logic [2:0] PH_WAIT   = 3'd4;
   localparam logic [2:0] PH_LAST   = 3'd5;

   logic               busy_ff;
   logic [2:0]         ph_ff;
   logic [IW-1:0]      n_ff;
   logic [KW-1:0]      k_ff;
   logic [KW-1:0]      kmax_ff;
   logic [IW-1:0]      lo_ff;
   logic [IW-1:0]      hi_ff;
   logic [IW-1:0]      plo_ff;
   logic [IW-1:0]      phi_ff;
   logic [IW-1:0]      i1_ff;
   logic [IW-1:0]      i2_ff;
   step_ctl_type       ctl_ff;
   step_ctl_type       ctl_in;

   logic [KW-1:0]      k_next;
   logic [IW-1:0]      nlo;
   logic [IW-1:0]      nhi;
   logic [IW-1:0]      pa;
   logic [IW-1:0]      pb;
   logic               pred_ok;
   logic [IW-1:0]      gi;
   logic [KW-1:0]      gj;

   // first row of diagonal k
   function automatic logic [IW-1:0] lo_of(input logic [KW-1:0] k, input logic [IW-1:0] n);
      logic [KW-1:0] kn;
      kn = KW'(n);
      if (k > kn) begin
         return IW'(k - kn);
      end
      return IW'(1);
   endfunction

   // last row of diagonal k
   function automatic logic [IW-1:0] hi_of(input logic [KW-1:0] k, input logic [IW-1:0] n);
      logic [KW-1:0] km;
      km = k - KW'(1);
      if (km < KW'(n)) begin
         return IW'(km);
      end
      return n;
   endfunction

   assign k_next = k_ff + KW'(1);
   assign nlo    = lo_of(k_next, n_ff);
   assign nhi    = hi_of(k_next, n_ff);

   // predecessor pair read in this phase
   always_comb begin
      case (ph_ff)
         PH_GRID_A: begin
            pa = i1_ff - IW'(1);
            pb = i2_ff - IW'(1);
         end
         PH_GRID_B: begin
            pa = i1_ff - IW'(1);
            pb = i2_ff;
         end
         PH_PRED_C: begin
            pa = i1_ff;
            pb = i2_ff - IW'(1);
         end
         default: begin
            pa = i1_ff;
            pb = i2_ff;
         end
      endcase
   end

   assign pred_ok = (pa >= plo_ff) && (pa <= phi_ff) && (pb >= plo_ff) && (pb <= phi_ff);

   assign gi = (ph_ff == PH_GRID_A) ? i1_ff : i2_ff;
   assign gj = k_ff - KW'(gi);

   assign grid_rd_addr = {RW'(gi - IW'(1)), RW'(gj - KW'(1))};
   assign dp_rd_addr   = {~k_ff[0], RW'(pa - IW'(1)), RW'(pb - IW'(1))};
   assign dp_wr_addr   = {k_ff[0], RW'(i1_ff - IW'(1)), RW'(i2_ff - IW'(1))};

   always_comb begin
      ctl_in = '0;
      if (busy_ff) begin
         ctl_in.shared  = (i1_ff == i2_ff);
         ctl_in.p_valid = pred_ok;
         case (ph_ff)
            PH_GRID_A: begin
               ctl_in.take_t1 = 1'b1;
               ctl_in.take_p  = 1'b1;
               ctl_in.first_p = 1'b1;
            end
            PH_GRID_B: begin
               ctl_in.take_t2 = 1'b1;
               ctl_in.take_p  = 1'b1;
            end
            PH_PRED_C, PH_PRED_D: begin
               ctl_in.take_p = 1'b1;
            end
            PH_WAIT: begin
               ctl_in.commit    = 1'b1;
               ctl_in.last_cell = (k_ff == kmax_ff);
            end
            default: begin
               ctl_in.take_p = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff   <= PH_GRID_A;
         ctl_ff  <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (start) begin
            busy_ff <= 1'b1;
            ph_ff   <= PH_GRID_A;
            n_ff    <= side;
            k_ff    <= KW'(2);
            kmax_ff <= KW'(side) << 1;
            lo_ff   <= lo_of(KW'(2), side);
            hi_ff   <= hi_of(KW'(2), side);
            plo_ff  <= lo_of(KW'(1), side);
            phi_ff  <= hi_of(KW'(1), side);
            i1_ff   <= lo_of(KW'(2), side);
            i2_ff   <= lo_of(KW'(2), side);
         end else if (busy_ff) begin
            if (ph_ff == PH_LAST) begin
               ph_ff <= PH_GRID_A;
               if (i2_ff != hi_ff) begin
                  i2_ff <= i2_ff + IW'(1);
               end else if (i1_ff != hi_ff) begin
                  i1_ff <= i1_ff + IW'(1);
                  i2_ff <= lo_ff;
               end else if (k_ff == kmax_ff) begin
                  busy_ff <= 1'b0;
               end else begin
                  k_ff   <= k_next;
                  plo_ff <= lo_ff;
                  phi_ff <= hi_ff;
                  lo_ff  <= nlo;
                  hi_ff  <= nhi;
                  i1_ff  <= nlo;
                  i2_ff  <= nlo;
               end
            end else begin
               ph_ff <= ph_ff + 3'd1;
            end
         end
      end
   end

   assign ctl  = ctl_ff;
   assign busy = busy_ff;

   `TPGM_ASSERT_NOW(a_walk_rows_in_diag, busy_ff,
      (i1_ff >= lo_ff) && (i1_ff <= hi_ff) && (i2_ff >= lo_ff) && (i2_ff <= hi_ff),
      "walk row pair left the current diagonal")
   `TPGM_ASSERT_NOW(a_walk_commit_phase, ctl_ff.commit, busy_ff && (ph_ff == PH_LAST),
      "entry committed outside its final phase")
   `TPGM_ASSERT_NEXT(a_walk_start_first_diag, start,
      busy_ff && (k_ff == KW'(2)) && (ph_ff == PH_GRID_A),
      "walk did not begin on the first diagonal")

endmodule

// ===== design/two_path_grid_max_sum_top.sv =====
// ----------------------------------------------------------------------------
// two_path_grid_max_sum_top
// best two-path sum over a square grid, dp held in ping-pong ram layers
// ----------------------------------------------------------------------------
// Cell writes arrive on req_chan, one item per cycle, and land in a grid ram
// of 2**(2*ceil(log2(MAX_SIDE))) entries (256 at the default). A row or column
// of zero or above MAX_SIDE writes nothing. The item with last set writes its
// cell and then starts the walk: for each anti-diagonal k = 2 .. 2n, every row
// pair (i1,i2) of the two paths gets one dp entry, built phase by phase by one
// read port on the grid ram and one on the dp ram (two grid reads, four
// predecessor reads, one write). n is the side register value, where zero is
// taken as one and values above MAX_SIDE as MAX_SIDE. The total (saturated at
// 22 bits) is then held in the rsp register until taken, and a clearing pass
// zeroes the grid ram, one entry a cycle; the same pass runs after reset.
// req_chan is not ready during the walk, during the clearing pass, or while a
// finished total waits for an earlier one to leave the rsp register. The side
// register on csr_chan is always ready and should only be written while the
// block idles.
// ----------------------------------------------------------------------------
`include "two_path_grid_max_sum_top_macros.svh"

module two_path_grid_max_sum_top import tpgm_pkg::*; #(
   parameter int MAX_SIDE = 16
) (
   input  logic    clock,
   input  logic    reset,
   tpgm_req_if.sink   req_chan,
   tpgm_rsp_if.source rsp_chan,
   tpgm_csr_if.sink   csr_chan
);

   localparam int RW  = $clog2(MAX_SIDE);
   localparam int IW  = $clog2(MAX_SIDE + 1);
   localparam int GAW = 2 * RW;
   localparam int DAW = 2 * RW + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FILL,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [GAW-1:0]     clr_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic [TOTAL_W-1:0] hold_ff;
   logic               rsp_valid_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   // fill side
   logic               req_take;
   logic               cell_in_range;
   logic               grid_wr_en;
   logic [GAW-1:0]     grid_wr_addr;
   logic [VALUE_W-1:0] grid_wr_data;

   // walk side
   logic [IW-1:0]      side_use;
   logic               walk_busy;
   step_ctl_type       ctl;
   logic [GAW-1:0]     grid_rd_addr;
   logic [VALUE_W-1:0] grid_rd_data;
   logic [DAW-1:0]     dp_rd_addr;
   logic [DAW-1:0]     dp_wr_addr;
   logic [TOTAL_W-1:0] dp_rd_data;
   logic [TOTAL_W-1:0] sum;
   logic               slot_free;

   assign req_chan.ready = (state_ff == ST_FILL);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // cells outside 1..MAX_SIDE are dropped
   assign cell_in_range = (req_chan.row != '0) && (int'(req_chan.row) <= MAX_SIDE) &&
                          (req_chan.col != '0) && (int'(req_chan.col) <= MAX_SIDE);

   // grid ram write: clearing sweep or a cell write, never both
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         grid_wr_en   = 1'b1;
         grid_wr_addr = clr_ff;
         grid_wr_data = '0;
      end else begin
         grid_wr_en   = req_take && cell_in_range;
         grid_wr_addr = {RW'(req_chan.row - COORD_W'(1)), RW'(req_chan.col - COORD_W'(1))};
         grid_wr_data = req_chan.value;
      end
   end

   // side in use: zero reads as one, clamp at MAX_SIDE
   always_comb begin
      if (side_ff == '0) begin
         side_use = IW'(1);
      end else if (int'(side_ff) > MAX_SIDE) begin
         side_use = IW'(MAX_SIDE);
      end else begin
         side_use = IW'(side_ff);
      end
   end

   // a finished total moves out once the rsp register is free
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (req_take && req_chan.last) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ctl.commit && ctl.last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         side_ff      <= SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            side_ff <= csr_chan.data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + GAW'(1);
         end
         // the corner entry is the only one on the last diagonal
         if ((state_ff == ST_WALK) && ctl.commit && ctl.last_cell) begin
            hold_ff <= sum;
         end
         if ((state_ff == ST_DONE) && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_total_ff <= hold_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.total = rsp_total_ff;

   // grid store; fill and walk never overlap, so no forwarding is needed
   tpgm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (2 ** GAW)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (grid_wr_data),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   // dp layers: top address bit picks the layer by diagonal parity; one
   // entry finishes before the next starts, so a layer is complete before
   // it is read
   tpgm_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (2 ** DAW)
   ) u_dp_ram (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (dp_wr_addr),
      .wr_data (sum),
      .rd_addr (dp_rd_addr),
      .rd_data (dp_rd_data)
   );

   tpgm_walk #(
      .MAX_SIDE (MAX_SIDE)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (req_take && req_chan.last),
      .side         (side_use),
      .grid_rd_addr (grid_rd_addr),
      .dp_rd_addr   (dp_rd_addr),
      .dp_wr_addr   (dp_wr_addr),
      .ctl          (ctl),
      .busy         (walk_busy)
   );

   tpgm_acc u_acc (
      .clock        (clock),
      .ctl          (ctl),
      .grid_rd_data (grid_rd_data),
      .dp_rd_data   (dp_rd_data),
      .sum          (sum)
   );

   `TPGM_ASSERT_NOW(a_top_walk_sync, 1'b1, walk_busy == (state_ff == ST_WALK),
      "walk sequencer and control state disagree")
   `TPGM_ASSERT_NOW(a_top_no_grid_write_in_walk, state_ff == ST_WALK, !grid_wr_en,
      "grid written while the walk reads it")
   `TPGM_ASSERT_NEXT(a_top_total_waits,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_chan.ready,
      (state_ff == ST_DONE) && rsp_valid_ff && $stable(rsp_total_ff),
      "pending total overwritten before it was taken")

endmodule

// ===== sim/grid_total_checker.sv =====
// ----------------------------------------------------------------------------
// grid_total_checker
// watches the cell, side and total channels, keeps its own grid and side
// register, predicts the best two-path total for every last item and
// compares each total taken from the block against the oldest prediction
// ----------------------------------------------------------------------------
module grid_total_checker import tpgm_pkg::*; #(
   parameter int MAX_SIDE = 16
) (
   input  logic clock,
   input  logic reset,
   tpgm_req_if  req_mon,
   tpgm_rsp_if  rsp_mon,
   tpgm_csr_if  csr_mon,
   output int   mismatch_count,
   output int   due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [VALUE_W-1:0] cells [1:MAX_SIDE][1:MAX_SIDE];
   logic [SIDE_W-1:0]  side_reg;
   logic [TOTAL_W-1:0] totals_due [$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic clear_cells();
      for (int r = 1; r <= MAX_SIDE; r++) begin
         for (int c = 1; c <= MAX_SIDE; c++) begin
            cells[r][c] = '0;
         end
      end
   endtask

   // two paths walked together one anti-diagonal at a time, indexed by rows
   function automatic logic [TOTAL_W-1:0] best_pair_total(input logic [SIDE_W-1:0] side_code);
      longint prev_layer [0:MAX_SIDE][0:MAX_SIDE];
      longint this_layer [0:MAX_SIDE][0:MAX_SIDE];
      longint best, gain;
      int n, ja, jb;
      n = int'(side_code);
      if (n < 1) n = 1;
      if (n > MAX_SIDE) n = MAX_SIDE;
      for (int a = 0; a <= MAX_SIDE; a++) begin
         for (int b = 0; b <= MAX_SIDE; b++) begin
            prev_layer[a][b] = 0;
            this_layer[a][b] = 0;
         end
      end
      for (int k = 2; k <= 2 * n; k++) begin
         for (int a = 0; a <= n; a++) begin
            for (int b = 0; b <= n; b++) begin
               ja = k - a;
               jb = k - b;
               if (a < 1 || b < 1 || ja < 1 || jb < 1 || ja > n || jb > n) begin
                  this_layer[a][b] = 0;
               end else begin
                  gain = longint'(cells[a][ja]);
                  // a shared cell counts once
                  if (a != b) gain += longint'(cells[b][jb]);
                  best = prev_layer[a-1][b-1];
                  if (prev_layer[a-1][b] > best) best = prev_layer[a-1][b];
                  if (prev_layer[a][b-1] > best) best = prev_layer[a][b-1];
                  if (prev_layer[a][b] > best) best = prev_layer[a][b];
                  best += gain;
                  this_layer[a][b] = (best > longint'(TOTAL_MAX)) ? longint'(TOTAL_MAX) : best;
               end
            end
         end
         prev_layer = this_layer;
      end
      return TOTAL_W'(prev_layer[n][n]);
   endfunction

   always @(posedge clock) begin
      logic [TOTAL_W-1:0] want;
      if (reset) begin
         side_reg = SIDE_RESET;
         clear_cells();
         totals_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) side_reg = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.row >= 1 && req_mon.row <= MAX_SIDE &&
                req_mon.col >= 1 && req_mon.col <= MAX_SIDE) begin
               cells[req_mon.row][req_mon.col] = req_mon.value;
            end
            if (req_mon.last) begin
               totals_due.push_back(best_pair_total(side_reg));
               clear_cells();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (totals_due.size() == 0) begin
               report_mismatch($sformatf("total %0d with none due", rsp_mon.total));
            end else begin
               want = totals_due.pop_front();
               if (rsp_mon.total !== want) begin
                  report_mismatch($sformatf("total %0d, predicted %0d", rsp_mon.total, want));
               end
            end
         end
      end
      due_count <= totals_due.size();
   end

endmodule

// ===== sim/two_path_grid_max_sum_top_test.sv =====
// ----------------------------------------------------------------------------
// two_path_grid_max_sum_top_test
// drives cell writes and side settings into the grid block, drains totals
// with random stalls and one long hold-off, and leaves the prediction and
// comparison to the checker; the verdict comes from its mismatch and due count
// ----------------------------------------------------------------------------
module two_path_grid_max_sum_top_test import tpgm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_MAX        = 16;
   localparam int CLK_PERIOD      = 10;
   // time for the clearing pass after each total, with some slack
   localparam int SETTLE_CYCLES   = 300;
   // long enough for two walks at side 2 to pile up behind the held total
   localparam int RSP_HOLD_CYCLES = 2000;
   // far above the length of a run where every item is a last item and
   // every stall is long
   localparam int TIMEOUT_CYCLES  = 20_000_000;

   logic clock;
   logic reset;
   bit   no_idle;        // when set neither side inserts gaps
   bit   rsp_hold_req;   // asks the total drain for one long hold-off
   int   mismatch_count;
   int   due_count;

   tpgm_req_if req_chan ();
   tpgm_rsp_if rsp_chan ();
   tpgm_csr_if csr_chan ();

   two_path_grid_max_sum_top #(.MAX_SIDE(GRID_MAX)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   grid_total_checker #(.MAX_SIDE(GRID_MAX)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .due_count      (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("FAILURE");
      $finish;
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // side in use as the block sees it: zero acts as one, big values clip
   function automatic int effective_side(input logic [SIDE_W-1:0] code);
      if (code == 0) return 1;
      if (code > GRID_MAX) return GRID_MAX;
      return int'(code);
   endfunction

   // offer one item and hold it until taken; valid stays up if no gap follows,
   // so back-to-back items never lower and raise valid in the same step
   task automatic send_cell(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                            input logic [VALUE_W-1:0] v, input logic fin);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.row   <= r;
      req_chan.col   <= c;
      req_chan.value <= v;
      req_chan.last  <= fin;
      do @(posedge clock); while (!req_chan.ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // side register write, only issued once the block has gone idle
   task automatic write_side(input logic [SIDE_W-1:0] side);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= side;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // wait until every predicted total has been taken, then let the clearing
   // pass run out; due_count is checked after the next edge so a just-taken last
   // item is already counted
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one grid load ending in a last item: mostly cells inside the side in
   // use, some beyond it, a few out of range; now and then the last item
   // itself points outside the grid
   task automatic send_random_set(input int n, input int max_len, inout int sent);
      int len, r, c, roll;
      logic [VALUE_W-1:0] v;
      logic fin;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
         fin  = (i == len - 1);
         roll = $urandom_range(0, 99);
         if (fin && $urandom_range(0, 9) == 0) roll = 99;
         if (roll < 85) begin
            r = $urandom_range(1, n);
            c = $urandom_range(1, n);
         end else if (roll < 93) begin
            r = $urandom_range(1, GRID_MAX);
            c = $urandom_range(1, GRID_MAX);
         end else begin
            r = $urandom_range(0, 1) ? 0 : $urandom_range(GRID_MAX + 1, 31);
            c = $urandom_range(0, 31);
         end
         roll = $urandom_range(0, 99);
         if (roll < 10) v = '0;
         else if (roll < 20) v = '1;
         else v = VALUE_W'($urandom_range(0, 65535));
         send_cell(COORD_W'(r), COORD_W'(c), v, fin);
         sent++;
      end
   endtask

   // total drain: random stalls, and one long hold-off on request
   initial begin : total_drain
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int side_plan [$];
      int eff, budget, max_len, sent;
      // mix of small, mid and full sides, plus zero and out-of-range codes
      side_plan = '{2, 4, 16, 1, 5, 0, 8, 3, 31, 6, 2, 7, 12};
      no_idle      = 1'b0;
      rsp_hold_req = 1'b0;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.row   <= '0;
      req_chan.col   <= '0;
      req_chan.value <= '0;
      req_chan.last  <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // side left at its reset value: corners, full-scale values, a crossing
      // pair, writes outside the grid, and a last item outside the grid
      send_cell(1, 1, 16'hFFFF, 1'b0);
      send_cell(16, 16, 16'hFFFF, 1'b0);
      send_cell(1, 16, 16'hFFFF, 1'b0);
      send_cell(16, 1, 16'hFFFF, 1'b0);
      send_cell(8, 9, 16'hAAAA, 1'b0);
      send_cell(9, 8, 16'h5555, 1'b0);
      send_cell(0, 5, 16'd1234, 1'b0);
      send_cell(5, 0, 16'd4321, 1'b0);
      send_cell(17, 3, 16'd777, 1'b0);
      send_cell(31, 31, 16'hFFFF, 1'b0);
      send_cell(0, 0, 16'd7, 1'b1);

      // small side with cells stored beyond it that must not count
      wait_idle();
      write_side(5'd3);
      send_cell(5, 5, 16'd9999, 1'b0);
      send_cell(2, 3, 16'd0, 1'b0);
      send_cell(3, 2, 16'hFFFF, 1'b0);
      send_cell(3, 3, 16'd100, 1'b1);

      // side code zero acts as a single cell, which both paths share
      wait_idle();
      write_side(5'd0);
      send_cell(1, 1, 16'd42, 1'b1);
      send_cell(2, 2, 16'd5, 1'b0);
      send_cell(1, 1, 16'hFFFF, 1'b1);

      // side code above the grid clips to full size; grid must be empty now
      wait_idle();
      write_side(5'd31);
      send_cell(31, 1, 16'd3, 1'b1);

      // back pressure: totals held off for a long stretch while short loads
      // keep coming, so a second total backs up and the input stalls
      wait_idle();
      write_side(5'd2);
      rsp_hold_req = 1'b1;
      sent = 0;
      repeat (30) send_random_set(2, 3, sent);

      // random phases, one side setting each; every fourth without gaps
      foreach (side_plan[p]) begin
         wait_idle();
         write_side(SIDE_W'(side_plan[p]));
         no_idle = (p % 4 == 3);
         eff     = effective_side(SIDE_W'(side_plan[p]));
         // big sides take long walks per total, keep them few
         budget  = (eff >= 12) ? 60 : (eff >= 8) ? 80 : 100;
         max_len = (eff * eff + 3 > 40) ? 40 : eff * eff + 3;
         sent    = 0;
         while (sent < budget) send_random_set(eff, max_len, sent);
      end

      no_idle = 1'b0;
      wait_idle();
      if (mismatch_count == 0 && due_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
